FILE: rtl/core/lbmpsm_pkg.sv
// Shared types, constants and fixed-point helpers for the D2Q9 partially
// saturated collision block. No dependencies.
package lbmpsm_pkg;

	localparam int NDIR = 9;
	localparam int DIV_LAT = 34;
	localparam int EQ_LAT = 5;

	typedef enum logic [1:0] {
		CFG_RELAX_RATE = 2'd0,
		CFG_SOLID_VEL_X = 2'd1,
		CFG_SOLID_VEL_Y = 2'd2
	} cfg_idx_t;

	localparam int EX_TAB [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
	localparam int EY_TAB [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
	localparam int OPP_TAB [NDIR] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};
	localparam int WSEL_TAB [NDIR] = '{0, 1, 1, 1, 1, 2, 2, 2, 2};

	typedef struct packed {
		logic signed [31:0] dist_rest;
		logic signed [31:0] dist_east;
		logic signed [31:0] dist_north;
		logic signed [31:0] dist_west;
		logic signed [31:0] dist_south;
		logic signed [31:0] dist_ne;
		logic signed [31:0] dist_nw;
		logic signed [31:0] dist_sw;
		logic signed [31:0] dist_se;
		logic [28:0] solid_weight;
	} cell_t;

	typedef struct packed {
		logic signed [31:0] post_rest;
		logic signed [31:0] post_east;
		logic signed [31:0] post_north;
		logic signed [31:0] post_west;
		logic signed [31:0] post_south;
		logic signed [31:0] post_ne;
		logic signed [31:0] post_nw;
		logic signed [31:0] post_sw;
		logic signed [31:0] post_se;
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
	} result_t;

	// Clamp a wide signed value to the 32-bit signed range.
	function automatic logic signed [31:0] sat_q(input logic signed [71:0] x);
		if (x > 72'sd2147483647) begin
			return 32'sh7fff_ffff;
		end else if (x < -72'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return x[31:0];
	endfunction

	// Constant-time clamp for elaboration constants.
	function automatic logic signed [31:0] sat_c(input longint x);
		return sat_q(72'(x));
	endfunction

	// Fixed-point product: round half up, then saturate.
	function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
			input logic signed [31:0] b, input int fb);
		logic signed [71:0] p;
		p = 72'(a) * 72'(b);
		p = p + (72'sd1 <<< (fb - 1));
		return sat_q(p >>> fb);
	endfunction

endpackage

FILE: rtl/core/lbmpsm_div.sv
// Pipelined restoring divider giving a saturated fixed-point quotient, one
// quotient bit per stage. Depends on lbmpsm_pkg.
module lbmpsm_div import lbmpsm_pkg::*; #(
	parameter int FRAC_BITS = 28
) (
	input logic clk,
	input logic en,
	input logic signed [31:0] num,
	input logic signed [31:0] den,
	output logic signed [31:0] quo
);
	localparam int CW = FRAC_BITS + 64;

	logic [63:0] r_q [0:31];
	logic [31:0] q_q [0:32];
	logic [31:0] d_q [0:31];
	logic neg_q [0:32];
	logic ovf_q [0:32];
	logic zero_q [0:32];
	logic signed [31:0] quo_q;

	logic [32:0] n_abs;
	logic [31:0] d_abs;
	logic [CW-1:0] n_sh;
	logic ovf_c;

	always_comb begin
		n_abs = num[31] ? 33'(-34'(num)) : 33'(num);
		d_abs = den[31] ? 32'(-33'(den)) : 32'(den);
		n_sh = CW'(n_abs) << FRAC_BITS;
		// A quotient of 2^32 or more saturates whatever its sign.
		ovf_c = n_sh >= (CW'(d_abs) << 32);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_q[0] <= n_sh[63:0];
			q_q[0] <= '0;
			d_q[0] <= d_abs;
			neg_q[0] <= num[31] != den[31];
			ovf_q[0] <= ovf_c;
			zero_q[0] <= den == 32'sd0;
		end
	end

	for (genvar j = 0; j < 32; j++) begin : g_step
		logic [63:0] dsh;
		logic ge;
		always_comb begin
			dsh = {32'b0, d_q[j]} << (31 - j);
			ge = r_q[j] >= dsh;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				q_q[j+1] <= {q_q[j][30:0], ge};
				neg_q[j+1] <= neg_q[j];
				ovf_q[j+1] <= ovf_q[j];
				zero_q[j+1] <= zero_q[j];
			end
		end
		// The last stage only needs the quotient bit, not the remainder.
		if (j < 31) begin : g_d
			always_ff @(posedge clk) begin
				if (en) begin
					r_q[j+1] <= ge ? r_q[j] - dsh : r_q[j];
					d_q[j+1] <= d_q[j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_q[32]) begin
				quo_q <= '0;
			end else if (ovf_q[32]) begin
				quo_q <= neg_q[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
			end else if (neg_q[32]) begin
				quo_q <= (q_q[32] > 32'h8000_0000) ? 32'sh8000_0000 : -q_q[32];
			end else begin
				quo_q <= q_q[32][31] ? 32'sh7fff_ffff : q_q[32];
			end
		end
	end

	assign quo = quo_q;
endmodule

FILE: rtl/core/lbmpsm_equil.sv
// One direction lane of the second-order equilibrium, five stages deep.
// Depends on lbmpsm_pkg.
module lbmpsm_equil import lbmpsm_pkg::*; #(
	parameter int FRAC_BITS = 28,
	parameter int EX = 0,
	parameter int EY = 0,
	parameter int WSEL = 0
) (
	input logic clk,
	input logic en,
	input logic signed [31:0] rho,
	input logic signed [31:0] vx,
	input logic signed [31:0] vy,
	output logic signed [31:0] feq
);
	localparam logic signed [31:0] ONE = sat_c(64'sd1 <<< FRAC_BITS);
	localparam logic signed [31:0] THREE = sat_c(64'sd3 <<< FRAC_BITS);
	localparam logic signed [31:0] FOUR_HALF = sat_c(64'sd9 <<< (FRAC_BITS - 1));
	localparam logic signed [31:0] ONE_HALF = sat_c(64'sd3 <<< (FRAC_BITS - 1));
	localparam longint W0 = ((64'sd8 <<< FRAC_BITS) + 9) / 18;
	localparam longint W1 = ((64'sd2 <<< FRAC_BITS) + 9) / 18;
	localparam longint W2 = ((64'sd2 <<< FRAC_BITS) + 36) / 72;
	localparam logic signed [31:0] WGT = sat_c(WSEL == 0 ? W0 : (WSEL == 1 ? W1 : W2));

	logic signed [33:0] tx, ty;
	logic signed [31:0] eu_s1, pxx_s1, pyy_s1, wr_s1;
	logic signed [31:0] uu_s2, t3_s2, ee_s2, wr_s2;
	logic signed [31:0] t3_s3, t45_s3, t15_s3, wr_s3;
	logic signed [31:0] poly_s4, wr_s4;
	logic signed [31:0] feq_s5;

	always_comb begin
		tx = (EX > 0) ? 34'(vx) : ((EX < 0) ? -34'(vx) : 34'sd0);
		ty = (EY > 0) ? 34'(vy) : ((EY < 0) ? -34'(vy) : 34'sd0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eu_s1 <= sat_q(72'(tx) + 72'(ty));
			pxx_s1 <= qmul(vx, vx, FRAC_BITS);
			pyy_s1 <= qmul(vy, vy, FRAC_BITS);
			wr_s1 <= qmul(WGT, rho, FRAC_BITS);

			uu_s2 <= sat_q(72'(pxx_s1) + 72'(pyy_s1));
			t3_s2 <= qmul(THREE, eu_s1, FRAC_BITS);
			ee_s2 <= qmul(eu_s1, eu_s1, FRAC_BITS);
			wr_s2 <= wr_s1;

			t3_s3 <= t3_s2;
			t45_s3 <= qmul(FOUR_HALF, ee_s2, FRAC_BITS);
			t15_s3 <= qmul(ONE_HALF, uu_s2, FRAC_BITS);
			wr_s3 <= wr_s2;

			poly_s4 <= sat_q(72'(ONE) + 72'(t3_s3) + 72'(t45_s3) - 72'(t15_s3));
			wr_s4 <= wr_s3;

			feq_s5 <= qmul(wr_s4, poly_s4, FRAC_BITS);
		end
	end

	assign feq = feq_s5;
endmodule

FILE: rtl/core/lattice_boltzmann_psm_collision.sv
// D2Q9 partially saturated BGK collision for one lattice cell per word.
//
// Channels: cell words enter on cell_word/cell_valid and leave on res/res_valid;
// the receiving side of each channel raises its stall to hold the word.
// Configuration (relax rate, solid velocity) is written on cfg_* with
// cfg_ready always high; write it only while no cell is in flight.
// Throughput: one cell per cycle while res_stall does not hold a waiting
// result, set by the fully pipelined divider (34 stages, one quotient bit
// per step stage) and the nine parallel equilibrium lanes per velocity.
// When res_stall holds a waiting result, the whole pipeline freezes and
// cell_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid flags and loads the register defaults: relax rate
// 1.0, solid velocity zero.
// Depends on lbmpsm_pkg, lbmpsm_div and lbmpsm_equil.
module lattice_boltzmann_psm_collision import lbmpsm_pkg::*; #(
	parameter int FRAC_BITS = 28
) (
	input logic clk,
	input logic arst_n,
	input logic cell_valid,
	output logic cell_stall,
	input cell_t cell_word,
	output logic res_valid,
	input logic res_stall,
	output result_t res,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);
	localparam int TAP = DIV_LAT + EQ_LAT;
	localparam logic signed [31:0] ONE = sat_c(64'sd1 <<< FRAC_BITS);

	logic [28:0] relax_q;
	logic signed [31:0] svx_q, svy_q;
	logic en;

	logic signed [31:0] fin [NDIR];
	logic signed [31:0] f_dq [0:TAP][NDIR];
	logic [28:0] b_dq [0:TAP];
	logic vld_dq [0:TAP];
	logic signed [31:0] rho_dq [0:DIV_LAT];
	logic signed [31:0] mx_s1, my_s1;
	logic signed [31:0] ux, uy;
	logic signed [31:0] feu [NDIR];
	logic signed [31:0] fes [NDIR];

	logic signed [31:0] om_s2 [NDIR], dd_s2 [NDIR], f_s2 [NDIR];
	logic signed [31:0] omb_s2;
	logic [28:0] b_s2;
	logic vld_s2;
	logic signed [31:0] m1_s3 [NDIR], bom_s3 [NDIR], f_s3 [NDIR];
	logic signed [31:0] sx_s3, sy_s3;
	logic [28:0] b_s3;
	logic vld_s3;
	logic signed [31:0] rel_s4 [NDIR], bom_s4 [NDIR], f_s4 [NDIR];
	logic signed [31:0] fx_s4, fy_s4;
	logic vld_s4;
	logic signed [31:0] post_s5 [NDIR];
	logic signed [31:0] fx_s5, fy_s5;
	logic vld_s5;
	logic signed [71:0] sx_c, sy_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relax_q <= 29'd268435456;
			svx_q <= '0;
			svy_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_RELAX_RATE: relax_q <= cfg_data[28:0];
				CFG_SOLID_VEL_X: svx_q <= cfg_data;
				CFG_SOLID_VEL_Y: svy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline advances as one unit unless a finished word is held.
	assign en = !(vld_s5 && res_stall);
	assign cell_stall = !en;

	always_comb begin
		fin[0] = cell_word.dist_rest;
		fin[1] = cell_word.dist_east;
		fin[2] = cell_word.dist_north;
		fin[3] = cell_word.dist_west;
		fin[4] = cell_word.dist_south;
		fin[5] = cell_word.dist_ne;
		fin[6] = cell_word.dist_nw;
		fin[7] = cell_word.dist_sw;
		fin[8] = cell_word.dist_se;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= TAP; i++) vld_dq[i] <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_dq[0] <= cell_valid;
			for (int i = 1; i <= TAP; i++) vld_dq[i] <= vld_dq[i-1];
			vld_s2 <= vld_dq[TAP];
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Moments of the incoming cell.
	always_ff @(posedge clk) begin
		if (en) begin
			f_dq[0] <= fin;
			b_dq[0] <= cell_word.solid_weight;
			rho_dq[0] <= sat_q(72'(fin[0]) + 72'(fin[1]) + 72'(fin[2]) + 72'(fin[3])
				+ 72'(fin[4]) + 72'(fin[5]) + 72'(fin[6]) + 72'(fin[7]) + 72'(fin[8]));
			mx_s1 <= sat_q(72'(fin[1]) - 72'(fin[3]) + 72'(fin[5]) - 72'(fin[6])
				- 72'(fin[7]) + 72'(fin[8]));
			my_s1 <= sat_q(72'(fin[2]) - 72'(fin[4]) + 72'(fin[5]) + 72'(fin[6])
				- 72'(fin[7]) - 72'(fin[8]));
			for (int i = 1; i <= TAP; i++) begin
				f_dq[i] <= f_dq[i-1];
				b_dq[i] <= b_dq[i-1];
			end
			for (int i = 1; i <= DIV_LAT; i++) rho_dq[i] <= rho_dq[i-1];
		end
	end

	lbmpsm_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk(clk), .en(en), .num(mx_s1), .den(rho_dq[0]), .quo(ux)
	);
	lbmpsm_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk(clk), .en(en), .num(my_s1), .den(rho_dq[0]), .quo(uy)
	);

	for (genvar k = 0; k < NDIR; k++) begin : g_lane
		lbmpsm_equil #(.FRAC_BITS(FRAC_BITS), .EX(EX_TAB[k]), .EY(EY_TAB[k]),
				.WSEL(WSEL_TAB[k])) u_eq_fluid (
			.clk(clk), .en(en), .rho(rho_dq[DIV_LAT]), .vx(ux), .vy(uy), .feq(feu[k])
		);
		lbmpsm_equil #(.FRAC_BITS(FRAC_BITS), .EX(EX_TAB[k]), .EY(EY_TAB[k]),
				.WSEL(WSEL_TAB[k])) u_eq_solid (
			.clk(clk), .en(en), .rho(rho_dq[DIV_LAT]), .vx(svx_q), .vy(svy_q),
			.feq(fes[k])
		);
	end

	// Merge of the lanes: force sums over all directions.
	always_comb begin
		sx_c = '0;
		sy_c = '0;
		for (int k = 0; k < NDIR; k++) begin
			if (EX_TAB[k] > 0) sx_c = sx_c + 72'(om_s2[k]);
			if (EX_TAB[k] < 0) sx_c = sx_c - 72'(om_s2[k]);
			if (EY_TAB[k] > 0) sy_c = sy_c + 72'(om_s2[k]);
			if (EY_TAB[k] < 0) sy_c = sy_c - 72'(om_s2[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NDIR; k++) begin
				om_s2[k] <= sat_q(72'(f_dq[TAP][OPP_TAB[k]]) - 72'(f_dq[TAP][k])
					+ 72'(fes[k]) - 72'(feu[OPP_TAB[k]]));
				dd_s2[k] <= sat_q(72'(feu[k]) - 72'(f_dq[TAP][k]));
				f_s2[k] <= f_dq[TAP][k];

				m1_s3[k] <= qmul(dd_s2[k], omb_s2, FRAC_BITS);
				bom_s3[k] <= qmul(32'(b_s2), om_s2[k], FRAC_BITS);
				f_s3[k] <= f_s2[k];

				rel_s4[k] <= qmul(m1_s3[k], 32'(relax_q), FRAC_BITS);
				bom_s4[k] <= bom_s3[k];
				f_s4[k] <= f_s3[k];

				post_s5[k] <= sat_q(72'(f_s4[k]) + 72'(rel_s4[k]) + 72'(bom_s4[k]));
			end
			omb_s2 <= sat_q(72'(ONE) - 72'(b_dq[TAP]));
			b_s2 <= b_dq[TAP];
			sx_s3 <= sat_q(sx_c);
			sy_s3 <= sat_q(sy_c);
			b_s3 <= b_s2;
			fx_s4 <= qmul(32'(b_s3), sx_s3, FRAC_BITS);
			fy_s4 <= qmul(32'(b_s3), sy_s3, FRAC_BITS);
			fx_s5 <= fx_s4;
			fy_s5 <= fy_s4;
		end
	end

	assign res_valid = vld_s5;
	assign res.post_rest = post_s5[0];
	assign res.post_east = post_s5[1];
	assign res.post_north = post_s5[2];
	assign res.post_west = post_s5[3];
	assign res.post_south = post_s5[4];
	assign res.post_ne = post_s5[5];
	assign res.post_nw = post_s5[6];
	assign res.post_sw = post_s5[7];
	assign res.post_se = post_s5[8];
	assign res.force_x = fx_s5;
	assign res.force_y = fy_s5;

`ifndef NO_ASSERTIONS
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |-> cell_stall)
		else $error("held result did not stall the input");
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> ($stable(vld_dq[TAP]) && $stable(vld_s4)))
		else $error("pipeline moved while the output was held");
	a_no_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_valid && res_stall) |-> !cell_stall)
		else $error("input stalled without a held result");
`endif
endmodule
